// ===== rtl/touch_adc_spi_frame_sampler_core_defines.svh =====
// assertion macros for the touch converter frame sampler rtl
`ifndef TOUCH_ADC_SPI_FRAME_SAMPLER_CORE_DEFINES_SVH
`define TOUCH_ADC_SPI_FRAME_SAMPLER_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TAFS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in a cycle implies a consequence in the same cycle
`define TAFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tafs_pkg.sv =====
// types, constants and control byte builder for the touch converter frame sampler
`timescale 1ns / 1ps

package tafs_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ACQUIRE_ENABLE   = 3'd0,
		REG_CHANNEL_CODE     = 3'd1,
		REG_EIGHT_BIT_MODE   = 3'd2,
		REG_SINGLE_ENDED     = 3'd3,
		REG_POWER_MODE       = 3'd4,
		REG_CHANGE_THRESHOLD = 3'd5
	} cfg_reg_t;

	// input item operations
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// channel selections
	typedef enum logic [1:0] {
		CH_A      = 2'd0,
		CH_B      = 2'd1,
		CH_C      = 2'd2,
		CH_UNUSED = 2'd3
	} chan_t;

	localparam logic [7:0]  CTRL_CH_A      = 8'hA0;
	localparam logic [7:0]  CTRL_CH_B      = 8'hD0;
	localparam logic [7:0]  CTRL_CH_C      = 8'h90;
	localparam logic [7:0]  CTRL_EIGHT_BIT = 8'h08;
	localparam logic [7:0]  CTRL_SINGLE    = 8'h04;
	localparam int unsigned CTRL_TICKS     = 8;
	localparam int unsigned FRAME_TICKS    = 24;
	localparam int unsigned WORD_W         = 16;
	localparam int unsigned SAMPLE_W       = 12;
	localparam int unsigned TICK_W         = 5;
	localparam logic [15:0] THRESH_RESET   = 16'd2;

	// live configuration
	typedef struct packed {
		logic        acquire_enable;
		logic [1:0]  channel_code;
		logic        eight_bit_mode;
		logic        single_ended;
		logic [1:0]  power_mode;
		logic [15:0] change_threshold;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic                serial_out;
		logic                clock_pulse;
		logic                chip_select_n;
		logic [SAMPLE_W-1:0] sample;
		logic                changed;
	} result_t;

	// control byte shifted out on the first eight ticks of a frame
	function automatic logic [7:0] build_ctrl_byte(input cfg_t cfg);
		logic [7:0] c;
		case (chan_t'(cfg.channel_code))
			CH_A:    c = CTRL_CH_A;
			CH_B:    c = CTRL_CH_B;
			CH_C:    c = CTRL_CH_C;
			default: c = 8'h00;
		endcase
		if (cfg.eight_bit_mode) c = c | CTRL_EIGHT_BIT;
		if (cfg.single_ended)   c = c | CTRL_SINGLE;
		c = c | {6'd0, cfg.power_mode};
		return c;
	endfunction

endpackage

// ===== rtl/touch_adc_spi_frame_sampler_core.sv =====
// top level of the touch converter frame sampler: config registers and result register
`timescale 1ns / 1ps

// Serial master for a touch or sense converter, stepped one beat at a time. A tick beat
// advances a 24-tick frame while acquire_enable is set: ticks 1 to 8 shift out the control
// byte msb first, then RX_BITS bits are clocked in msb first and the finished word is kept,
// with the changed flag set, when it differs from the last kept word by more than
// change_threshold. A read beat returns the upper 12 bits of the receive word and the flag,
// and clears the flag. Every beat gives one result beat. The frame update and the 16-bit
// difference compare sit between the frame state registers and the result register, so a new
// beat is taken every cycle while the result register is free or being drained. Configuration
// is written through cfg_valid/cfg_ready, always ready, and is meant to change only while no
// beat is in flight.
module touch_adc_spi_frame_sampler_core import tafs_pkg::*; #(
	parameter int unsigned RX_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// input beats
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic                serial_in,
	// result beats
	output logic                out_valid,
	input  logic                out_stall,
	output logic                serial_out,
	output logic                clock_pulse,
	output logic                chip_select_n,
	output logic [SAMPLE_W-1:0] sample,
	output logic                changed
);

	cfg_t    cfg_q;
	logic    in_accept;
	result_t result;
	result_t result_q;
	logic    out_valid_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.acquire_enable   <= 1'b0;
			cfg_q.channel_code     <= 2'd0;
			cfg_q.eight_bit_mode   <= 1'b0;
			cfg_q.single_ended     <= 1'b0;
			cfg_q.power_mode       <= 2'd0;
			cfg_q.change_threshold <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACQUIRE_ENABLE:   cfg_q.acquire_enable   <= cfg_data[0];
				REG_CHANNEL_CODE:     cfg_q.channel_code     <= cfg_data[1:0];
				REG_EIGHT_BIT_MODE:   cfg_q.eight_bit_mode   <= cfg_data[0];
				REG_SINGLE_ENDED:     cfg_q.single_ended     <= cfg_data[0];
				REG_POWER_MODE:       cfg_q.power_mode       <= cfg_data[1:0];
				REG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// take a beat whenever the result register is empty or draining
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	tafs_frame_engine #(
		.RX_BITS(RX_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (in_accept),
		.op       (op_t'(opcode)),
		.serial_in(serial_in),
		.cfg      (cfg_q),
		.result   (result)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign serial_out    = result_q.serial_out;
	assign clock_pulse   = result_q.clock_pulse;
	assign chip_select_n = result_q.chip_select_n;
	assign sample        = result_q.sample;
	assign changed       = result_q.changed;

endmodule

// ===== rtl/tafs_frame_engine.sv =====
// frame state, serial shift and change detection for one tick or read per cycle
`timescale 1ns / 1ps
`include "touch_adc_spi_frame_sampler_core_defines.svh"

module tafs_frame_engine import tafs_pkg::*; #(
	parameter int unsigned RX_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  op_t     op,
	input  logic    serial_in,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int unsigned BL_W    = $clog2(RX_BITS + 1);
	localparam int unsigned POS_OFS = WORD_W - RX_BITS;

	logic [TICK_W-1:0] tick_count_q;
	logic              receiving_q;
	logic [BL_W-1:0]   bits_left_q;
	logic [WORD_W-1:0] receive_word_q;
	logic [WORD_W-1:0] accepted_word_q;
	logic              change_flag_q;
	logic              last_out_bit_q;

	logic              tick_go;
	logic              read_go;
	logic [TICK_W-1:0] tick_inc;
	logic [TICK_W-1:0] tick_next;
	logic              in_ctrl;
	logic [2:0]        ctrl_idx;
	logic [7:0]        ctrl_byte;
	logic              start_rx;
	logic              rx_active;
	logic [BL_W-1:0]   bl_norm;
	logic [BL_W-1:0]   bl_dec;
	logic [3:0]        bit_pos;
	logic [WORD_W-1:0] word_base;
	logic [WORD_W-1:0] word_new;
	logic              rx_done;
	logic [WORD_W:0]   diff_ab;
	logic [WORD_W:0]   diff_ba;
	logic [WORD_W-1:0] abs_diff;
	logic              keep_word;
	logic              out_bit;

	assign tick_go = go && (op == OP_TICK) && cfg.acquire_enable;
	assign read_go = go && (op == OP_READ);

	// tick position inside the frame
	assign tick_inc  = tick_count_q + TICK_W'(1);
	assign tick_next = (tick_inc >= TICK_W'(FRAME_TICKS)) ? '0 : tick_inc;

	// control byte, msb first on ticks one to eight
	assign ctrl_byte = build_ctrl_byte(cfg);
	assign in_ctrl   = (tick_inc >= TICK_W'(1)) && (tick_inc <= TICK_W'(CTRL_TICKS));
	assign ctrl_idx  = 3'(TICK_W'(CTRL_TICKS) - tick_inc);
	assign out_bit   = (tick_go && in_ctrl) ? ctrl_byte[ctrl_idx] : last_out_bit_q;

	// receive shift, msb first from tick nine
	assign start_rx  = (tick_inc == TICK_W'(CTRL_TICKS + 1));
	assign rx_active = receiving_q || start_rx;
	assign bl_norm   = ((bits_left_q == '0) || (bits_left_q > BL_W'(RX_BITS))) ?
		BL_W'(RX_BITS) : bits_left_q;
	assign bl_dec    = bl_norm - BL_W'(1);
	assign bit_pos   = 4'(bl_dec + BL_W'(POS_OFS));
	assign word_base = start_rx ? '0 : receive_word_q;
	assign word_new  = rx_active ? (word_base | (WORD_W'(serial_in) << bit_pos)) : word_base;
	assign rx_done   = rx_active && (bl_dec == '0);

	// absolute difference against the last kept word
	assign diff_ab   = {1'b0, word_new} - {1'b0, accepted_word_q};
	assign diff_ba   = {1'b0, accepted_word_q} - {1'b0, word_new};
	assign abs_diff  = diff_ab[WORD_W] ? diff_ba[WORD_W-1:0] : diff_ab[WORD_W-1:0];
	assign keep_word = tick_go && rx_done && (abs_diff > cfg.change_threshold);

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			receiving_q     <= 1'b0;
			bits_left_q     <= BL_W'(RX_BITS);
			receive_word_q  <= '0;
			accepted_word_q <= '0;
			change_flag_q   <= 1'b0;
			last_out_bit_q  <= 1'b0;
		end else if (read_go) begin
			change_flag_q <= 1'b0;
		end else if (tick_go) begin
			tick_count_q   <= tick_next;
			last_out_bit_q <= out_bit;
			receive_word_q <= word_new;
			if (rx_active) begin
				receiving_q <= !rx_done;
				bits_left_q <= rx_done ? BL_W'(RX_BITS) : bl_dec;
			end
			if (keep_word) begin
				accepted_word_q <= word_new;
				change_flag_q   <= 1'b1;
			end
		end
	end

	// result of this beat
	always_comb begin
		result.serial_out    = tick_go ? out_bit : last_out_bit_q;
		result.clock_pulse   = tick_go && (in_ctrl || rx_active);
		result.chip_select_n = !cfg.acquire_enable;
		result.sample        = tick_go ? word_new[WORD_W-1 -: SAMPLE_W] :
			receive_word_q[WORD_W-1 -: SAMPLE_W];
		result.changed       = read_go ? change_flag_q : 1'b0;
	end

	`TAFS_ASSERT_ALWAYS(a_tick_in_frame, clk, arst_n, tick_count_q < TICK_W'(FRAME_TICKS), "tick count left the frame")
	`TAFS_ASSERT_ALWAYS(a_bits_left_range, clk, arst_n, (bits_left_q != '0) && (bits_left_q <= BL_W'(RX_BITS)), "bits left out of range")
	`TAFS_ASSERT_IMPLIES(a_rx_window, clk, arst_n, receiving_q, (tick_count_q > TICK_W'(CTRL_TICKS)) && (tick_count_q < TICK_W'(CTRL_TICKS + RX_BITS)), "receiving outside the data window")
	`TAFS_ASSERT_IMPLIES(a_flag_set_by_tick, clk, arst_n, $rose(change_flag_q), $past(tick_go), "change flag set without a tick")

endmodule
